// ===== design/rfth_pkg.sv =====
// Shared types, constants and coefficient helper for the two-pixel row filter.
// Used by rfth_front, rfth_back and the top level; depends on nothing.
package rfth_pkg;

  localparam int unsigned TapsDef      = 9;
  localparam int unsigned CoefFracDef  = 16;
  localparam int unsigned MaxTaps      = 15;
  localparam int unsigned QueueDepth   = 2;
  localparam longint unsigned DecimalOne = 64'd1000000000;

  localparam logic [23:0] ThresholdRst = 24'h800000;
  localparam logic [15:0] RowWidthRst  = 16'd640;

  // coefficients scaled by 10^9, oldest tap first; unused taps are zero
  localparam longint unsigned CoefE9 [MaxTaps] = '{
    64'd251770, 64'd8666992, 64'd78025818, 64'd241302490, 64'd343757629,
    64'd241302490, 64'd78025818, 64'd8666992, 64'd125885,
    64'd0, 64'd0, 64'd0, 64'd0, 64'd0, 64'd0
  };

  typedef enum logic [1:0] {
    KIND_EMPTY = 2'd0,
    KIND_DATA  = 2'd1,
    KIND_END   = 2'd2
  } kind_e;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] raw_first;
    logic [7:0] raw_second;
  } rfth_meta_t;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] raw_first;
    logic [7:0] raw_second;
    logic       above_first;
    logic       above_second;
  } rfth_res_t;

  // unsigned Q0.frac coefficient, rounded half up
  function automatic longint unsigned coef_fixed(input int unsigned k,
                                                 input int unsigned frac);
    longint unsigned c;
    c = CoefE9[k % MaxTaps];
    return ((c << frac) + DecimalOne / 2) / DecimalOne;
  endfunction

endpackage

// ===== design/rfth_fifo.sv =====
// Small register queue with push/full and pop/empty sides.
// Generic in width and depth; no package dependency.
module rfth_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             empty_o,
  output logic [WIDTH-1:0] data_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(DEPTH))
    else $error("queue count beyond depth");

  a_push_only_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_push && !do_pop |=> cnt_q == $past(cnt_q) + CntW'(1))
    else $error("queue count did not grow on push");

endmodule

// ===== design/rfth_front.sv =====
// Front end: accepts items, keeps the pixel window, fill and column count,
// and classifies each item. Depends on rfth_pkg.
module rfth_front import rfth_pkg::*; #(
  parameter int unsigned TAPS = TapsDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  output logic                  full_o,
  input  logic [7:0]            pixel_first_i,
  input  logic [7:0]            pixel_second_i,
  input  logic                  end_marker_i,
  input  logic [15:0]           row_width_i,
  input  logic                  q_full_i,
  output logic                  q_push_o,
  output rfth_meta_t            meta_o,
  output logic [(TAPS+1)*8-1:0] seq_o
);

  localparam int unsigned FillW = $clog2(TAPS);

  logic [7:0]       win_q [TAPS-1];
  logic [FillW-1:0] fill_q, fill_d;
  logic [16:0]      cnt_q, cnt_d, cnt_inc;
  logic [FillW:0]   fill_inc;
  logic             accept, is_data;

  assign full_o   = q_full_i;
  assign accept   = push_i && !q_full_i;
  assign q_push_o = accept;

  // fill saturates at TAPS-1, so a full window means the filter can run
  assign is_data  = (fill_q == FillW'(TAPS - 1));
  assign fill_inc = {1'b0, fill_q} + (FillW + 1)'(2);
  assign cnt_inc  = cnt_q + 17'd2;

  always_comb begin
    for (int j = 0; j < TAPS - 1; j++) begin
      seq_o[j*8 +: 8] = win_q[j];
    end
    seq_o[(TAPS-1)*8 +: 8] = pixel_first_i;
    seq_o[TAPS*8 +: 8]     = pixel_second_i;
  end

  always_comb begin
    meta_o.kind       = KIND_EMPTY;
    meta_o.raw_first  = '0;
    meta_o.raw_second = '0;
    if (end_marker_i) begin
      meta_o.kind = KIND_END;
    end else if (is_data) begin
      meta_o.kind       = KIND_DATA;
      meta_o.raw_first  = pixel_first_i;
      meta_o.raw_second = pixel_second_i;
    end
  end

  always_comb begin
    fill_d = fill_q;
    cnt_d  = cnt_q;
    if (accept && !end_marker_i) begin
      if (fill_inc >= (FillW + 1)'(TAPS - 1)) begin
        fill_d = FillW'(TAPS - 1);
      end else begin
        fill_d = fill_inc[FillW-1:0];
      end
      cnt_d = cnt_inc;
      if (cnt_inc >= {1'b0, row_width_i}) begin
        cnt_d  = '0;
        fill_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      cnt_q  <= '0;
    end else begin
      fill_q <= fill_d;
      cnt_q  <= cnt_d;
    end
  end

  // window shifts two pixels per item; stale entries are masked by fill
  always_ff @(posedge clk_i) begin
    if (accept && !end_marker_i) begin
      for (int j = 0; j < TAPS - 1; j++) begin
        win_q[j] <= seq_o[(j+2)*8 +: 8];
      end
    end
  end

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FillW'(TAPS - 1))
    else $error("window fill beyond window size");

  a_end_keeps_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && end_marker_i |=> $stable(fill_q) && $stable(cnt_q))
    else $error("end item changed row state");

endmodule

// ===== design/rfth_back.sv =====
// Back end: takes classified items from the middle queue, forms both
// filter sums, registers them, then compares with the threshold.
// Depends on rfth_pkg.
module rfth_back import rfth_pkg::*; #(
  parameter int unsigned TAPS           = TapsDef,
  parameter int unsigned COEF_FRAC_BITS = CoefFracDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  q_empty_i,
  output logic                  q_pop_o,
  input  rfth_meta_t            meta_i,
  input  logic [(TAPS+1)*8-1:0] seq_i,
  input  logic [23:0]           threshold_i,
  input  logic                  out_full_i,
  output logic                  out_push_o,
  output rfth_res_t             res_o
);

  localparam int unsigned CoefW = COEF_FRAC_BITS;
  localparam int unsigned SumW  = 8 + COEF_FRAC_BITS + $clog2(TAPS);
  localparam int unsigned CmpW  = SumW + 24;
  localparam int unsigned ShL   = (COEF_FRAC_BITS < 16) ? 16 - COEF_FRAC_BITS : 0;
  localparam int unsigned ShR   = (COEF_FRAC_BITS >= 16) ? COEF_FRAC_BITS - 16 : 0;

  logic [SumW-1:0] sum_first, sum_second;
  logic [SumW-1:0] s1_sum_first_q, s1_sum_second_q;
  rfth_meta_t      s1_meta_q;
  logic            s1_v_q, s1_v_d;
  logic [CmpW-1:0] thr_aligned, lhs_first, lhs_second;
  logic            s1_load;

  // constant-coefficient products; older offset and newer offset
  always_comb begin
    sum_first  = '0;
    sum_second = '0;
    for (int k = 0; k < TAPS; k++) begin
      sum_first  = sum_first + SumW'(CoefW'(coef_fixed(k, COEF_FRAC_BITS)))
                   * SumW'(seq_i[k*8 +: 8]);
      sum_second = sum_second + SumW'(CoefW'(coef_fixed(k, COEF_FRAC_BITS)))
                   * SumW'(seq_i[(k+1)*8 +: 8]);
    end
  end

  assign s1_load    = !q_empty_i && (!s1_v_q || !out_full_i);
  assign q_pop_o    = s1_load;
  assign out_push_o = s1_v_q && !out_full_i;

  always_comb begin
    s1_v_d = s1_v_q;
    if (s1_load) begin
      s1_v_d = 1'b1;
    end else if (!out_full_i) begin
      s1_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else begin
      s1_v_q <= s1_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_load) begin
      s1_meta_q       <= meta_i;
      s1_sum_first_q  <= sum_first;
      s1_sum_second_q <= sum_second;
    end
  end

  // align the Q8.16 threshold with the sums' binary point
  assign thr_aligned = CmpW'(threshold_i) << ShR;
  assign lhs_first   = CmpW'(s1_sum_first_q) << ShL;
  assign lhs_second  = CmpW'(s1_sum_second_q) << ShL;

  always_comb begin
    res_o.kind         = s1_meta_q.kind;
    res_o.raw_first    = s1_meta_q.raw_first;
    res_o.raw_second   = s1_meta_q.raw_second;
    res_o.above_first  = (s1_meta_q.kind == KIND_DATA) && (lhs_first >= thr_aligned);
    res_o.above_second = (s1_meta_q.kind == KIND_DATA) && (lhs_second >= thr_aligned);
  end

  a_flags_only_on_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_push_o && res_o.kind != KIND_DATA |-> !res_o.above_first && !res_o.above_second)
    else $error("threshold flag set on a non-data item");

endmodule

// ===== design/row_fir_threshold_two_pixel.sv =====
// Two-pixel row filter with threshold flags: top level with register port.
// Instantiates rfth_front, rfth_back and two rfth_fifo queues; uses rfth_pkg.
//
// Each item carries two pixels of a row (or an end marker) and yields exactly one
// result: end for an end marker, else empty until the window holds enough pixels,
// then data with the raw pixels and two flags telling whether the 9-tap filter sum
// at the older and newer offset reaches the threshold. One item is accepted and one
// result delivered per clock while the queues are not full. The rate is set by the
// combinational constant-coefficient adder tree of each offset, which is registered
// before the threshold compare. No start-up clearing is needed after reset.
// Registers: threshold at address 0 (Q8.16), row_width at address 4.
module row_fir_threshold_two_pixel import rfth_pkg::*; #(
  parameter int unsigned TAPS           = TapsDef,
  parameter int unsigned COEF_FRAC_BITS = CoefFracDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  pixel_first_i,
  input  logic [7:0]  pixel_second_i,
  input  logic        end_marker_i,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  kind_o,
  output logic [7:0]  raw_first_o,
  output logic [7:0]  raw_second_o,
  output logic        above_first_o,
  output logic        above_second_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned SeqW = (TAPS + 1) * 8;
  localparam int unsigned MidW = $bits(rfth_meta_t) + SeqW;
  localparam int unsigned ResW = $bits(rfth_res_t);
  localparam logic RegThreshold = 1'b0;
  localparam logic RegRowWidth  = 1'b1;

  logic [23:0]     threshold_q;
  logic [15:0]     row_width_q;
  logic            cfg_write;
  logic            reg_sel;

  rfth_meta_t      fr_meta, bk_meta;
  logic [SeqW-1:0] fr_seq, bk_seq;
  logic            mid_push, mid_full, mid_pop, mid_empty;
  logic [MidW-1:0] mid_head;
  logic            out_push, out_full;
  rfth_res_t       bk_res, out_res;
  logic [ResW-1:0] out_head;

  // register port
  assign pready    = 1'b1;
  assign reg_sel   = paddr[2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q <= ThresholdRst;
      row_width_q <= RowWidthRst;
    end else if (cfg_write) begin
      case (reg_sel)
        RegThreshold: threshold_q <= pwdata[23:0];
        RegRowWidth:  row_width_q <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      RegThreshold: prdata = {8'd0, threshold_q};
      RegRowWidth:  prdata = {16'd0, row_width_q};
      default:      prdata = '0;
    endcase
  end

  rfth_front #(
    .TAPS (TAPS)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push_i         (push),
    .full_o         (full),
    .pixel_first_i  (pixel_first_i),
    .pixel_second_i (pixel_second_i),
    .end_marker_i   (end_marker_i),
    .row_width_i    (row_width_q),
    .q_full_i       (mid_full),
    .q_push_o       (mid_push),
    .meta_o         (fr_meta),
    .seq_o          (fr_seq)
  );

  rfth_fifo #(
    .WIDTH (MidW),
    .DEPTH (QueueDepth)
  ) u_mid_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (mid_push),
    .data_i  ({fr_meta, fr_seq}),
    .full_o  (mid_full),
    .pop_i   (mid_pop),
    .empty_o (mid_empty),
    .data_o  (mid_head)
  );

  assign bk_meta = mid_head[MidW-1:SeqW];
  assign bk_seq  = mid_head[SeqW-1:0];

  rfth_back #(
    .TAPS           (TAPS),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (mid_empty),
    .q_pop_o     (mid_pop),
    .meta_i      (bk_meta),
    .seq_i       (bk_seq),
    .threshold_i (threshold_q),
    .out_full_i  (out_full),
    .out_push_o  (out_push),
    .res_o       (bk_res)
  );

  rfth_fifo #(
    .WIDTH (ResW),
    .DEPTH (QueueDepth)
  ) u_out_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (out_push),
    .data_i  (bk_res),
    .full_o  (out_full),
    .pop_i   (pop),
    .empty_o (empty),
    .data_o  (out_head)
  );

  assign out_res        = out_head;
  assign kind_o         = out_res.kind;
  assign raw_first_o    = out_res.raw_first;
  assign raw_second_o   = out_res.raw_second;
  assign above_first_o  = out_res.above_first;
  assign above_second_o = out_res.above_second;

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for row_fir_threshold_two_pixel: queue-style pixel and result
// ports, APB register writes, and an in-line predictor of the 9-tap row filter.
// Depends on rfth_pkg (kinds, result struct, reset values) and the block's top level.
module testbench;
  import rfth_pkg::*;

  localparam logic [2:0] ADDR_THRESHOLD = 3'd0;
  localparam logic [2:0] ADDR_ROW_WIDTH = 3'd4;
  localparam int unsigned FILTER_TAPS = 9;
  localparam int unsigned STUCK_LIMIT = 4000;
  localparam int unsigned ITEMS_PER_SEGMENT = 240;
  localparam int unsigned EXPECT_DEPTH = 4096;
  // filter taps scaled by 10^9, oldest pixel first
  localparam longint unsigned TAP_E9 [FILTER_TAPS] = '{
    64'd251770, 64'd8666992, 64'd78025818, 64'd241302490, 64'd343757629,
    64'd241302490, 64'd78025818, 64'd8666992, 64'd125885
  };

  logic        clk_i;
  logic        rst_ni;
  logic        push;
  logic        full;
  logic [7:0]  pixel_first_i;
  logic [7:0]  pixel_second_i;
  logic        end_marker_i;
  logic        empty;
  logic        pop = 1'b0;
  logic [1:0]  kind_o;
  logic [7:0]  raw_first_o;
  logic [7:0]  raw_second_o;
  logic        above_first_o;
  logic        above_second_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  // predictor state and register copies
  logic [7:0]  row_window [8];
  int unsigned window_fill;
  logic [16:0] column_count;
  logic [23:0] threshold_q;
  logic [15:0] row_width_q;
  int unsigned tap_q16 [FILTER_TAPS];

  // expected results in order; written by the sender, read by the checker
  rfth_res_t   expect_mem [EXPECT_DEPTH];
  int unsigned expect_wr = 0;
  int unsigned expect_rd = 0;
  int unsigned idle_pct;
  int unsigned stall_pct;
  int unsigned fail_count = 0;
  int unsigned items_sent;
  int unsigned end_items;
  int unsigned results_checked = 0;
  int unsigned data_results;
  int unsigned flags_set;
  int unsigned stuck_cycles;

  row_fir_threshold_two_pixel u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .pixel_first_i  (pixel_first_i),
    .pixel_second_i (pixel_second_i),
    .end_marker_i   (end_marker_i),
    .empty          (empty),
    .pop            (pop),
    .kind_o         (kind_o),
    .raw_first_o    (raw_first_o),
    .raw_second_o   (raw_second_o),
    .above_first_o  (above_first_o),
    .above_second_o (above_second_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  task automatic report_fail(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("%t: %s", $realtime, msg);
  endtask

  // Advances the row filter by one item and returns the result it must produce.
  function automatic rfth_res_t row_filter_predict(input logic [7:0] p1, input logic [7:0] p2,
                                                   input logic end_mark);
    rfth_res_t   r;
    logic [7:0]  seq [10];
    logic [31:0] sum_old;
    logic [31:0] sum_new;
    r = '0;
    if (end_mark) begin
      r.kind = KIND_END;
      return r;
    end
    r.kind = KIND_EMPTY;
    if (window_fill == 8) begin
      for (int k = 0; k < 8; k++) seq[k] = row_window[k];
      seq[8] = p1;
      seq[9] = p2;
      sum_old = '0;
      sum_new = '0;
      for (int k = 0; k < FILTER_TAPS; k++) begin
        sum_old += tap_q16[k] * seq[k];
        sum_new += tap_q16[k] * seq[k + 1];
      end
      r.kind         = KIND_DATA;
      r.raw_first    = p1;
      r.raw_second   = p2;
      r.above_first  = (sum_old >= {8'h00, threshold_q});
      r.above_second = (sum_new >= {8'h00, threshold_q});
      for (int k = 0; k < 8; k++) row_window[k] = seq[k + 2];
    end else begin
      row_window[window_fill]     = p1;
      row_window[window_fill + 1] = p2;
      window_fill += 2;
    end
    column_count = column_count + 17'd2;
    if (column_count >= {1'b0, row_width_q}) begin
      column_count = '0;
      window_fill  = 0;
    end
    return r;
  endfunction

  // Called just after a falling edge; returns just after a falling edge.
  task automatic send_pair(input logic [7:0] p1, input logic [7:0] p2, input logic end_mark);
    rfth_res_t due;
    while ($urandom_range(99) < idle_pct) begin
      push <= 1'b0;
      @(negedge clk_i);
    end
    push           <= 1'b1;
    pixel_first_i  <= p1;
    pixel_second_i <= p2;
    end_marker_i   <= end_mark;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    due = row_filter_predict(p1, p2, end_mark);
    expect_mem[expect_wr % EXPECT_DEPTH] = due;
    expect_wr++;
    items_sent++;
    if (end_mark) end_items++;
    if (due.kind == KIND_DATA) begin
      data_results++;
      flags_set += due.above_first + due.above_second;
    end
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    while (expect_wr != expect_rd) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic reg_write(input logic [2:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i);
    // read back through a second transfer
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (prdata !== data)
      report_fail($sformatf("register at %0d reads %h, wrote %h", addr, prdata, data));
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic set_config(input logic [23:0] thr, input logic [15:0] rw);
    wait_drained();
    // output pipeline is two stages deep
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    reg_write(ADDR_THRESHOLD, {8'h00, thr});
    threshold_q = thr;
    reg_write(ADDR_ROW_WIDTH, {16'h0000, rw});
    row_width_q = rw;
  endtask

  task automatic test_directed();
    idle_pct  = 0;
    stall_pct = 0;
    // reset values: threshold 0x800000, row width 640
    send_pair(8'hFF, 8'hFF, 1'b1);
    send_pair(8'h00, 8'h00, 1'b0);
    send_pair(8'hFF, 8'hFF, 1'b0);
    send_pair(8'hAA, 8'h55, 1'b1);  // end item while the window fills
    send_pair(8'hFF, 8'h00, 1'b0);
    send_pair(8'h00, 8'hFF, 1'b0);
    send_pair(8'h80, 8'h7F, 1'b0);
    send_pair(8'hFF, 8'hFF, 1'b0);
    send_pair(8'h00, 8'h00, 1'b0);
    // zero threshold, row clears on the same item as its first data
    set_config(24'h000000, 16'd10);
    send_pair(8'h01, 8'h80, 1'b0);
    send_pair(8'h02, 8'h40, 1'b0);
    send_pair(8'h04, 8'h20, 1'b0);
    send_pair(8'h08, 8'h10, 1'b0);
    send_pair(8'hFE, 8'hFD, 1'b0);
    send_pair(8'h00, 8'h01, 1'b0);
    // max threshold never reached, odd row width
    set_config(24'hFFFFFF, 16'd9);
    repeat (5) send_pair(8'hFF, 8'hFF, 1'b0);
    // tiny row widths clear after every item
    set_config(24'h800000, 16'd0);
    send_pair(8'hFF, 8'h00, 1'b0);
    send_pair(8'h00, 8'hFF, 1'b0);
    set_config(24'h800000, 16'd1);
    send_pair(8'h55, 8'hAA, 1'b0);
  endtask

  task automatic test_random_phase(input int unsigned send_idle, input int unsigned pop_stall,
                                   input logic [15:0] first_rw);
    logic [23:0] thr;
    logic [15:0] rw;
    logic [7:0]  p1;
    logic [7:0]  p2;
    int unsigned roll;
    for (int seg = 0; seg < 2; seg++) begin
      if ($urandom_range(3) == 0) thr = 24'($urandom_range(24'hFFFFFF));
      else thr = 24'($urandom_range(24'hC00000, 24'h400000));
      if (seg == 0) rw = first_rw;
      else begin
        case ($urandom_range(9))
          0: rw = 16'd2;
          1: rw = 16'd3;
          2: rw = 16'd8;
          3: rw = 16'd9;
          4: rw = 16'd640;
          5: rw = 16'd65535;
          default: rw = 16'($urandom_range(40, 10));
        endcase
      end
      set_config(thr, rw);
      idle_pct  = send_idle;
      stall_pct = pop_stall;
      for (int n = 0; n < ITEMS_PER_SEGMENT; n++) begin
        if (seg == 0 && n == ITEMS_PER_SEGMENT / 2) wait_drained();
        roll = $urandom_range(99);
        if (roll < 15) begin
          p1 = 8'($urandom_range(255, 200));
          p2 = 8'($urandom_range(255, 200));
        end else if (roll < 30) begin
          p1 = 8'($urandom_range(50));
          p2 = 8'($urandom_range(50));
        end else begin
          p1 = 8'($urandom_range(255));
          p2 = 8'($urandom_range(255));
        end
        send_pair(p1, p2, ($urandom_range(99) < 6));
      end
      idle_pct  = 0;
      stall_pct = 0;
    end
  endtask

  // result checker
  always @(posedge clk_i) begin
    rfth_res_t want;
    rfth_res_t got;
    if (rst_ni && pop && !empty) begin
      got = {kind_o, raw_first_o, raw_second_o, above_first_o, above_second_o};
      if (expect_wr == expect_rd) begin
        report_fail($sformatf("result with nothing expected: kind %0d raw %h/%h above %b%b",
                              kind_o, raw_first_o, raw_second_o, above_first_o,
                              above_second_o));
      end else begin
        want = expect_mem[expect_rd % EXPECT_DEPTH];
        expect_rd++;
        results_checked++;
        if (got !== want)
          report_fail($sformatf("expected kind %0d raw %h/%h above %b%b, got kind %0d %s",
                                want.kind, want.raw_first, want.raw_second, want.above_first,
                                want.above_second, kind_o,
                                $sformatf("raw %h/%h above %b%b", raw_first_o, raw_second_o,
                                          above_first_o, above_second_o)));
      end
    end
  end

  // receiver stalls
  always @(negedge clk_i) begin
    if (rst_ni) pop <= ($urandom_range(99) >= stall_pct);
    else pop <= 1'b0;
  end

  // watchdog on cycles without any accepted transfer
  always @(posedge clk_i) begin
    if (!rst_ni || (push && !full) || (pop && !empty) || psel) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("testbench: errors");
        $finish;
      end
    end
  end

  initial begin
    for (int k = 0; k < FILTER_TAPS; k++)
      tap_q16[k] = int'(((TAP_E9[k] << 16) + 64'd500000000) / 64'd1000000000);
    rst_ni          = 1'b0;
    push            = 1'b0;
    pixel_first_i   = '0;
    pixel_second_i  = '0;
    end_marker_i    = 1'b0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    window_fill     = 0;
    column_count    = '0;
    threshold_q     = ThresholdRst;
    row_width_q     = RowWidthRst;
    idle_pct        = 0;
    stall_pct       = 0;
    items_sent      = 0;
    end_items       = 0;
    data_results    = 0;
    flags_set       = 0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed();
    test_random_phase(0, 0, 16'd65535);
    test_random_phase(60, 0, 16'd10);
    test_random_phase(0, 60, 16'd16);
    test_random_phase(26, 26, 16'd11);

    wait_drained();
    repeat (8) @(posedge clk_i);
    $display("Sent %0d items (%0d end markers) over 13 register settings and 4 idle mixes;",
             items_sent, end_items);
    $display("checked %0d results, %0d carrying filter data with %0d flags set.",
             results_checked, data_results, flags_set);
    if (fail_count == 0) $display("testbench: clean");
    else $display("testbench: errors");
    $finish;
  end

endmodule
